FILE: hdl/status_led_blink_controller_assert.svh
// Assertion macros for the status LED blink controller.
// Included by the top level; needs nothing else.
`ifndef STATUS_LED_BLINK_CONTROLLER_ASSERT_SVH
`define STATUS_LED_BLINK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SLBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slbc same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SLBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slbc next-cycle check failed");

`endif

FILE: hdl/slbc_pkg.sv
// Shared types and codes for the status LED blink controller.
// No dependencies.
package slbc_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL     = 2'd0,
      MODE_ALTERNATE  = 2'd1,
      MODE_CONCURRENT = 2'd2,
      MODE_ERROR      = 2'd3
   } mode_type;

   localparam logic [2:0] ACT_TICK        = 3'd0;
   localparam logic [2:0] ACT_SET_MOTOR   = 3'd1;
   localparam logic [2:0] ACT_SET_MODE    = 3'd2;
   localparam logic [2:0] ACT_REPORT_ERR  = 3'd3;
   localparam logic [2:0] ACT_CLEAR_ERR   = 3'd4;

   localparam logic [1:0] LED_OFF    = 2'd0;
   localparam logic [1:0] LED_FIRST  = 2'd1;
   localparam logic [1:0] LED_SECOND = 2'd2;
   localparam logic [1:0] LED_BOTH   = 2'd3;

   localparam logic [15:0] INTERVAL_RESET = 16'd1;

   // CSR register indexes (word address)
   localparam logic REG_BLINK_INTERVAL = 1'b0;

   typedef struct packed {
      logic        fire;
      logic [2:0]  action;
      logic [1:0]  motor_state;
      mode_type    display_mode;
      logic [31:0] error_code;
   } core_in_type;

   typedef struct packed {
      logic [1:0] led_pattern;
      mode_type   active_mode;
   } core_out_type;

endpackage

FILE: hdl/slbc_core.sv
// Event processing and LED state for the status LED blink controller.
// Depends on slbc_pkg.
module slbc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [15:0]                blink_interval,
   input  slbc_pkg::core_in_type      core_in,
   output slbc_pkg::core_out_type     core_out
);

   slbc_pkg::mode_type mode_ff, mode_in;
   logic [1:0]  motor_ff, motor_in;
   logic [1:0]  led_ff, led_in;
   logic [15:0] tick_ff, tick_in;
   logic [31:0] err_ff, err_in;
   logic [5:0]  slot_ff, slot_in;
   logic [5:0]  width_ff, width_in;

   // error display step
   logic [31:0] es_code;
   logic [5:0]  es_slot;
   logic [5:0]  es_width;
   logic [5:0]  es_width_use;
   logic [1:0]  es_led;
   logic [6:0]  es_next;
   logic [5:0]  es_slot_next;
   logic [15:0] tick_inc;

   // Bit width of the code: index of the top set bit plus one, at least one.
   function automatic logic [5:0] code_width(input logic [31:0] code);
      logic [5:0] w;
      w = 6'd1;
      for (int i = 1; i < 32; i++) begin
         if (code[i]) begin
            w = 6'(i + 1);
         end
      end
      return w;
   endfunction

   function automatic logic [1:0] toggle_alt(input logic [1:0] led);
      return (led == slbc_pkg::LED_FIRST) ? slbc_pkg::LED_SECOND : slbc_pkg::LED_FIRST;
   endfunction

   function automatic logic [1:0] toggle_conc(input logic [1:0] led);
      return (led == slbc_pkg::LED_OFF) ? slbc_pkg::LED_BOTH : slbc_pkg::LED_OFF;
   endfunction

   // A report restarts the sequence from the start mark with the new code, unless already in error mode with that code.
   always_comb begin
      es_code = (core_in.action == slbc_pkg::ACT_REPORT_ERR) ? core_in.error_code : err_ff;
      es_slot = (core_in.action == slbc_pkg::ACT_REPORT_ERR) ? 6'd0 : slot_ff;
      es_width = code_width(es_code);
      if (es_slot == 6'd0) begin
         es_led       = slbc_pkg::LED_BOTH;
         es_width_use = es_width;
      end else if (!es_slot[0]) begin
         es_led       = slbc_pkg::LED_OFF;
         es_width_use = width_ff;
      end else begin
         es_led       = es_code[es_slot[5:1]] ? slbc_pkg::LED_SECOND : slbc_pkg::LED_FIRST;
         es_width_use = width_ff;
      end
      es_next      = {1'b0, es_slot} + 7'd1;
      es_slot_next = (es_next >= {es_width_use, 1'b0}) ? 6'd0 : es_next[5:0];
   end

   always_comb begin
      mode_in  = mode_ff;
      motor_in = motor_ff;
      led_in   = led_ff;
      tick_in  = tick_ff;
      err_in   = err_ff;
      slot_in  = slot_ff;
      width_in = width_ff;
      tick_inc = tick_ff + 16'd1;
      case (core_in.action)
         slbc_pkg::ACT_TICK: begin
            if (blink_interval <= tick_inc) begin
               tick_in = 16'd0;
               case (mode_ff)
                  slbc_pkg::MODE_ALTERNATE:  led_in = toggle_alt(led_ff);
                  slbc_pkg::MODE_CONCURRENT: led_in = toggle_conc(led_ff);
                  slbc_pkg::MODE_ERROR: begin
                     led_in   = es_led;
                     slot_in  = es_slot_next;
                     width_in = es_width_use;
                  end
                  default: ;
               endcase
            end else begin
               tick_in = tick_inc;
            end
         end
         slbc_pkg::ACT_SET_MOTOR: begin
            motor_in = core_in.motor_state;
            if (mode_ff != slbc_pkg::MODE_ERROR) begin
               mode_in = slbc_pkg::MODE_NORMAL;
               led_in  = core_in.motor_state;
            end
         end
         slbc_pkg::ACT_SET_MODE: begin
            if (mode_ff != core_in.display_mode) begin
               tick_in = 16'd0;
               mode_in = core_in.display_mode;
               if (core_in.display_mode == slbc_pkg::MODE_ALTERNATE) begin
                  led_in = toggle_alt(led_ff);
               end else if (core_in.display_mode == slbc_pkg::MODE_CONCURRENT) begin
                  led_in = toggle_conc(led_ff);
               end
            end
         end
         slbc_pkg::ACT_REPORT_ERR: begin
            if (!(mode_ff == slbc_pkg::MODE_ERROR && err_ff == core_in.error_code)) begin
               mode_in  = slbc_pkg::MODE_ERROR;
               err_in   = core_in.error_code;
               led_in   = es_led;
               slot_in  = es_slot_next;
               width_in = es_width_use;
            end
         end
         slbc_pkg::ACT_CLEAR_ERR: begin
            if (mode_ff == slbc_pkg::MODE_ERROR) begin
               mode_in = slbc_pkg::MODE_NORMAL;
               led_in  = motor_ff;
            end
         end
         default: ;
      endcase
      core_out.led_pattern = led_in;
      core_out.active_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= slbc_pkg::MODE_NORMAL;
         motor_ff <= 2'd0;
         led_ff   <= slbc_pkg::LED_OFF;
         tick_ff  <= 16'd0;
         err_ff   <= 32'd0;
         slot_ff  <= 6'd0;
         width_ff <= 6'd1;
      end else if (core_in.fire) begin
         mode_ff  <= mode_in;
         motor_ff <= motor_in;
         led_ff   <= led_in;
         tick_ff  <= tick_in;
         err_ff   <= err_in;
         slot_ff  <= slot_in;
         width_ff <= width_in;
      end
   end

endmodule

FILE: hdl/status_led_blink_controller.sv
// Path: an accepted transaction is held in the input register, then in the result register, which drives rsp_valid.
// Throughput: one transaction per cycle while rsp_stall is low; the LED state update is one register pass.
// Backpressure: rsp_stall holds the result register, then the input register, then req_stall.
// Reset (synchronous, active high): pipeline emptied, normal mode, LEDs off, tick count
// cleared, stored error code zero, error width one, blink_interval back to one.
// Depends on slbc_pkg, slbc_core and status_led_blink_controller_assert.svh.
`include "status_led_blink_controller_assert.svh"

module status_led_blink_controller (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [1:0]  req_motor_state,
   input  logic [1:0]  req_display_mode,
   input  logic [31:0] req_error_code,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_led_pattern,
   output logic [1:0]  rsp_active_mode,
   // configuration port (APB style)
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ---------------------------------------------------------------
   // Configuration register: blink_interval at byte address 0.
   // Any byte offset inside the word maps to the same register.
   // ---------------------------------------------------------------
   logic [15:0] interval_ff, interval_in;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      interval_in = interval_ff;
      if (csr_write && paddr[2] == slbc_pkg::REG_BLINK_INTERVAL) begin
         interval_in = pwdata[15:0];
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == slbc_pkg::REG_BLINK_INTERVAL) begin
         prdata = {16'd0, interval_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= slbc_pkg::INTERVAL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control. Stage 1 is the input register, stage 2 the
   // result register. Stage 1 advances (and the core commits its
   // state) whenever the result register is empty or being drained.
   // ---------------------------------------------------------------
   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_action_ff;
   logic [1:0]  s1_motor_ff;
   logic [1:0]  s1_mode_ff;
   logic [31:0] s1_code_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_ready;
   logic        s1_ready;
   logic        req_fire;

   slbc_pkg::core_in_type  core_in;
   slbc_pkg::core_out_type core_out;
   slbc_pkg::core_out_type rsp_ff;

   assign out_ready = ~rsp_valid_ff | ~rsp_stall;
   assign s1_ready  = ~s1_valid_ff | out_ready;
   assign req_stall = reset | ~s1_ready;
   assign req_fire  = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_ready) begin
         s1_valid_in = req_valid;
      end
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input transaction register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= req_action;
         s1_motor_ff  <= req_motor_state;
         s1_mode_ff   <= req_display_mode;
         s1_code_ff   <= req_error_code;
      end
   end

   assign core_in.fire         = s1_valid_ff & out_ready;
   assign core_in.action       = s1_action_ff;
   assign core_in.motor_state  = s1_motor_ff;
   assign core_in.display_mode = slbc_pkg::mode_type'(s1_mode_ff);
   assign core_in.error_code   = s1_code_ff;

   slbc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .blink_interval (interval_ff),
      .core_in        (core_in),
      .core_out       (core_out)
   );

   // result register: LED code and mode after the transaction
   always_ff @(posedge clock) begin
      if (core_in.fire) begin
         rsp_ff <= core_out;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_pattern = rsp_ff.led_pattern;
   assign rsp_active_mode = rsp_ff.active_mode;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // an accepted transaction always lands in the input register
   `SLBC_ASSERT_NEXT(a_accept_lands, clock, reset, req_fire, s1_valid_ff)
   // a held transaction is not dropped while the output is blocked
   `SLBC_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !out_ready,
                     s1_valid_ff && $stable(s1_action_ff))
   // clearing an error never leaves the block in error mode
   `SLBC_ASSERT_NOW(a_clear_leaves_error, clock, reset,
                    core_in.fire && core_in.action == slbc_pkg::ACT_CLEAR_ERR,
                    core_out.active_mode != slbc_pkg::MODE_ERROR)

endmodule
